### rtl/cstk_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity top-K package
// Shared sizes, codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package cstk_pkg;

	localparam int VECTOR_DIM  = 384;
	localparam int MAX_TOP_K   = 16;
	localparam int INDEX_BITS  = 16;

	localparam int ELEM_W      = 16;
	localparam int SIM_W       = 16;
	localparam int RANK_W      = 4;
	localparam int OP_W        = 2;
	localparam int TOPK_W      = 5;
	localparam int ACC_W       = 48;
	localparam int HALF_W      = ACC_W / 2;
	localparam int PROD_W      = 2 * ACC_W;
	localparam int ROOT_W      = ACC_W;
	localparam int FRAC_BITS   = 14;
	localparam int QUO_W       = ACC_W + FRAC_BITS;
	localparam int STEP_W      = $clog2(QUO_W + 1);

	localparam int CNT_W       = $clog2(VECTOR_DIM + 2);
	localparam int ADDR_W      = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
	localparam int KCNT_W      = $clog2(MAX_TOP_K + 1);
	localparam int KIDX_W      = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [SIM_W-1:0]  ONE_Q14     = SIM_W'(16384);
	localparam logic [TOPK_W-1:0] TOP_K_RESET = TOPK_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_QUERY  = 2'd0,
		OP_CORPUS = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQRT,
		ST_DIV,
		ST_CLAMP,
		ST_INSERT,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic                   finish;
		logic                   len_ok;
		logic [INDEX_BITS-1:0]  index;
		logic signed [ACC_W-1:0] dot;
		logic [ACC_W-1:0]       qnorm;
		logic [ACC_W-1:0]       cnorm;
	} job_t;

endpackage

### rtl/cstk_if.sv
// ----------------------------------------------------------------------------
// Cosine similarity top-K channel interfaces
// Valid/ready channels for input items, results and the top_k register.
// ----------------------------------------------------------------------------
interface cstk_in_if;
	import cstk_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [ELEM_W-1:0] element_value;
	logic                     last_element;
	modport source (output valid, op, element_value, last_element, input ready);
	modport sink (input valid, op, element_value, last_element, output ready);
endinterface

interface cstk_out_if;
	import cstk_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [RANK_W-1:0]        rank;
	logic [INDEX_BITS-1:0]    corpus_index;
	logic signed [SIM_W-1:0]  similarity;
	logic                     last_result;
	modport source (output valid, rank, corpus_index, similarity, last_result, input ready);
	modport sink (input valid, rank, corpus_index, similarity, last_result, output ready);
endinterface

interface cstk_cfg_if;
	import cstk_pkg::*;
	logic              valid;
	logic              ready;
	logic [TOPK_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/cstk_front.sv
// ----------------------------------------------------------------------------
// Cosine similarity top-K front end
// One element per cycle while space is high; keeps query, sums dot and norms.
// ----------------------------------------------------------------------------
module cstk_front (
	input  logic           clk,
	input  logic           arst_n,
	cstk_in_if.sink        items,
	input  logic           space,
	output logic           push,
	output cstk_pkg::job_t push_job
);
	import cstk_pkg::*;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         qlen_q;
	logic [CNT_W-1:0]         base_cnt;
	logic [CNT_W-1:0]         next_cnt;
	logic                     loading_q;
	logic [INDEX_BITS-1:0]    cidx_q;
	logic                     accept;
	logic                     is_q;
	logic                     is_c;
	logic                     is_f;
	logic                     in_range;
	logic                     len_ok;
	logic [ADDR_W-1:0]        addr;
	logic signed [ELEM_W-1:0] qstore [VECTOR_DIM];

	logic                     valid_s1;
	logic                     q_s1;
	logic                     c_s1;
	logic                     f_s1;
	logic                     last_s1;
	logic                     in_range_s1;
	logic                     dot_en_s1;
	logic                     clr_vec_s1;
	logic                     clr_q_s1;
	logic                     len_ok_s1;
	logic signed [ELEM_W-1:0] v_s1;
	logic signed [ELEM_W-1:0] rd_s1;
	logic [INDEX_BITS-1:0]    idx_s1;

	logic signed [ACC_W-1:0]    dot_q;
	logic signed [ACC_W-1:0]    dot_b;
	logic signed [ACC_W-1:0]    dot_n;
	logic signed [ACC_W-1:0]    prod_x;
	logic [ACC_W-1:0]           cn_q;
	logic [ACC_W-1:0]           cn_b;
	logic [ACC_W-1:0]           cn_n;
	logic [ACC_W-1:0]           qn_q;
	logic [ACC_W-1:0]           qn_b;
	logic [ACC_W-1:0]           qn_n;
	logic signed [2*ELEM_W-1:0] prod;
	logic signed [2*ELEM_W-1:0] sq_s;
	logic [2*ELEM_W-1:0]        sq;

	assign items.ready = space;
	assign accept      = items.valid && items.ready;
	assign is_q        = accept && (items.op == OP_QUERY);
	assign is_c        = accept && (items.op == OP_CORPUS);
	assign is_f        = accept && (items.op == OP_FINISH);

	// A query element while no query is loading starts a new one; a corpus
	// element during loading closes the query and starts a fresh vector.
	always_comb begin
		if (items.op == OP_QUERY) begin
			base_cnt = loading_q ? count_q : '0;
		end else begin
			base_cnt = loading_q ? '0 : count_q;
		end
		in_range = base_cnt < CNT_W'(VECTOR_DIM);
		next_cnt = in_range ? base_cnt + 1'b1 : CNT_W'(VECTOR_DIM + 1);
		len_ok   = (next_cnt == qlen_q) && in_range;
		addr     = base_cnt[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			qlen_q    <= '0;
			loading_q <= 1'b0;
			cidx_q    <= '0;
		end else if (accept) begin
			case (items.op)
				OP_QUERY: begin
					loading_q <= !items.last_element;
					count_q   <= items.last_element ? '0 : next_cnt;
					qlen_q    <= next_cnt;
				end
				OP_CORPUS: begin
					loading_q <= 1'b0;
					count_q   <= items.last_element ? '0 : next_cnt;
					if (items.last_element) begin
						cidx_q <= cidx_q + 1'b1;
					end
				end
				OP_FINISH: begin
					loading_q <= 1'b0;
					count_q   <= '0;
					cidx_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_q && in_range) begin
			qstore[addr] <= items.element_value;
		end
		rd_s1 <= qstore[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= is_q || is_c || is_f;
		end
	end

	always_ff @(posedge clk) begin
		q_s1        <= is_q;
		c_s1        <= is_c;
		f_s1        <= is_f;
		last_s1     <= items.last_element;
		in_range_s1 <= in_range;
		dot_en_s1   <= in_range && (base_cnt < qlen_q);
		clr_vec_s1  <= is_q ? !loading_q : loading_q;
		clr_q_s1    <= !loading_q;
		len_ok_s1   <= len_ok;
		v_s1        <= items.element_value;
		idx_s1      <= cidx_q;
	end

	always_comb begin
		prod   = rd_s1 * v_s1;
		sq_s   = v_s1 * v_s1;
		sq     = unsigned'(sq_s);
		prod_x = {{(ACC_W - 2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
		dot_b  = clr_vec_s1 ? '0 : dot_q;
		cn_b   = clr_vec_s1 ? '0 : cn_q;
		qn_b   = (q_s1 && clr_q_s1) ? '0 : qn_q;
		dot_n  = (c_s1 && dot_en_s1) ? dot_b + prod_x : dot_b;
		cn_n   = (c_s1 && in_range_s1) ? cn_b + ACC_W'(sq) : cn_b;
		qn_n   = (q_s1 && in_range_s1) ? qn_b + ACC_W'(sq) : qn_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			cn_q  <= '0;
			qn_q  <= '0;
		end else if (valid_s1) begin
			if (f_s1 || (c_s1 && last_s1)) begin
				dot_q <= '0;
				cn_q  <= '0;
			end else begin
				dot_q <= dot_n;
				cn_q  <= cn_n;
			end
			qn_q <= qn_n;
		end
	end

	assign push            = valid_s1 && (f_s1 || (c_s1 && last_s1));
	assign push_job.finish = f_s1;
	assign push_job.len_ok = len_ok_s1;
	assign push_job.index  = idx_s1;
	assign push_job.dot    = dot_n;
	assign push_job.qnorm  = qn_n;
	assign push_job.cnorm  = cn_n;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(VECTOR_DIM + 1))
		else $error("element count beyond saturation value");
	a_qlen_range: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= CNT_W'(VECTOR_DIM + 1))
		else $error("query length beyond saturation value");
	a_push_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(f_s1 && c_s1))
		else $error("job is both a finish and a corpus vector");
`endif

endmodule

### rtl/cstk_queue.sv
// ----------------------------------------------------------------------------
// Cosine similarity top-K job queue
// Short queue of finished vectors and finish markers between front and back.
// ----------------------------------------------------------------------------
module cstk_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cstk_pkg::job_t push_job,
	output logic           space,
	input  logic           pop,
	output cstk_pkg::job_t pop_job,
	output logic           not_empty
);
	import cstk_pkg::*;

	job_t              slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	// One slot stays free for the transaction still in the front's
	// accumulate stage.
	assign space     = count_q < (QPTR_W + 1)'(QUEUE_DEPTH - 1);
	assign not_empty = count_q != '0;
	assign pop_job   = slots[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < (QPTR_W + 1)'(QUEUE_DEPTH)))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("job queue count beyond depth");
`endif

endmodule

### rtl/cstk_back.sv
// ----------------------------------------------------------------------------
// Cosine similarity top-K back end
// Computes the Q2.14 similarity, keeps the sorted list and emits it.
// ----------------------------------------------------------------------------
module cstk_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        not_empty,
	input  cstk_pkg::job_t              pop_job,
	output logic                        pop,
	input  logic [cstk_pkg::TOPK_W-1:0] top_k,
	cstk_out_if.source                  results
);
	import cstk_pkg::*;

	back_state_t state_q;
	back_state_t state_d;
	logic [STEP_W-1:0]       step_q;
	logic signed [ACC_W-1:0] dot_q;
	logic [ACC_W-1:0]        an_q;
	logic [ACC_W-1:0]        bn_q;
	logic [ACC_W-1:0]        mag;
	logic [INDEX_BITS-1:0]   idx_q;
	logic [PROD_W-1:0]       prod_q;
	logic [HALF_W-1:0]       mul_a;
	logic [HALF_W-1:0]       mul_b;
	logic [2*HALF_W-1:0]     pp;
	logic [PROD_W-1:0]       pp_sh;
	logic [ROOT_W-1:0]       root_q;
	logic [ROOT_W+1:0]       rem_q;
	logic [ROOT_W+1:0]       rem_sh;
	logic [ROOT_W+1:0]       trial;
	logic                    sq_ge;
	logic [QUO_W-1:0]        dvd_q;
	logic [QUO_W-1:0]        quo_q;
	logic [ROOT_W-1:0]       drem_q;
	logic [ROOT_W:0]         drem_sh;
	logic [ROOT_W:0]         drem_sub;
	logic                    div_ge;
	logic                    neg_q;
	logic [SIM_W-1:0]        sim_mag;
	logic signed [SIM_W-1:0] sim_q;

	logic [INDEX_BITS-1:0]   best_idx_q [MAX_TOP_K];
	logic signed [SIM_W-1:0] best_sim_q [MAX_TOP_K];
	logic [KCNT_W-1:0]       best_cnt_q;
	logic [KCNT_W-1:0]       ptr_q;
	logic [KCNT_W-1:0]       k_eff;
	logic [KCNT_W-1:0]       n_eff;
	logic [KCNT_W-1:0]       pos;
	logic [KCNT_W-1:0]       new_n;
	logic                    emit_load;

	logic                    out_valid_q;
	logic [RANK_W-1:0]       out_rank_q;
	logic [INDEX_BITS-1:0]   out_idx_q;
	logic signed [SIM_W-1:0] out_sim_q;
	logic                    out_last_q;

	always_comb begin
		if (int'(top_k) > MAX_TOP_K) begin
			k_eff = KCNT_W'(MAX_TOP_K);
		end else begin
			k_eff = KCNT_W'(top_k);
		end
		n_eff = (best_cnt_q < k_eff) ? best_cnt_q : k_eff;
		new_n = (n_eff < k_eff) ? n_eff + 1'b1 : k_eff;
		// The list is sorted best first, so the lowest entry that is worse
		// than the new value is the insertion point; equal values stay ahead.
		pos = n_eff;
		for (int i = MAX_TOP_K - 1; i >= 0; i--) begin
			if ((KCNT_W'(i) < n_eff) && (best_sim_q[i] < sim_q)) begin
				pos = KCNT_W'(i);
			end
		end
	end

	// Norm product in four 24x24 partial products.
	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				mul_a = an_q[HALF_W-1:0];
				mul_b = bn_q[HALF_W-1:0];
			end
			2'd1: begin
				mul_a = an_q[HALF_W-1:0];
				mul_b = bn_q[ACC_W-1:HALF_W];
			end
			2'd2: begin
				mul_a = an_q[ACC_W-1:HALF_W];
				mul_b = bn_q[HALF_W-1:0];
			end
			default: begin
				mul_a = an_q[ACC_W-1:HALF_W];
				mul_b = bn_q[ACC_W-1:HALF_W];
			end
		endcase
		pp = mul_a * mul_b;
		case (step_q[1:0])
			2'd0:    pp_sh = PROD_W'(pp);
			2'd3:    pp_sh = PROD_W'(pp) << ACC_W;
			default: pp_sh = PROD_W'(pp) << HALF_W;
		endcase
	end

	always_comb begin
		rem_sh   = {rem_q[ROOT_W-1:0], prod_q[PROD_W-1 -: 2]};
		trial    = {root_q, 2'b01};
		sq_ge    = rem_sh >= trial;
		drem_sh  = {drem_q, dvd_q[QUO_W-1]};
		div_ge   = drem_sh >= {1'b0, root_q};
		drem_sub = drem_sh - {1'b0, root_q};
		mag      = dot_q[ACC_W-1] ? unsigned'(-dot_q) : unsigned'(dot_q);
		sim_mag  = (quo_q > QUO_W'(ONE_Q14)) ? ONE_Q14 : quo_q[SIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (not_empty) begin
					pop = 1'b1;
					if (pop_job.finish) begin
						state_d = ST_EMIT;
					end else if (!pop_job.len_ok || (pop_job.qnorm == '0) ||
						(pop_job.cnorm == '0)) begin
						state_d = ST_INSERT;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				if (step_q == STEP_W'(3)) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(QUO_W - 1)) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = ST_INSERT;
			end
			ST_INSERT: begin
				state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (ptr_q == n_eff) begin
					state_d = ST_IDLE;
				end else begin
					emit_load = !out_valid_q || results.ready;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			best_cnt_q <= '0;
			ptr_q      <= '0;
		end else begin
			step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if (state_q == ST_IDLE) begin
				ptr_q <= '0;
			end else if (emit_load) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if ((state_q == ST_INSERT) && (pos < k_eff)) begin
				best_cnt_q <= new_n;
			end else if ((state_q == ST_EMIT) && (ptr_q == n_eff)) begin
				best_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					dot_q  <= pop_job.dot;
					an_q   <= pop_job.qnorm;
					bn_q   <= pop_job.cnorm;
					idx_q  <= pop_job.index;
					prod_q <= '0;
					rem_q  <= '0;
					root_q <= '0;
					sim_q  <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= prod_q + pp_sh;
			end
			ST_SQRT: begin
				prod_q <= prod_q << 2;
				rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				if (state_d == ST_DIV) begin
					neg_q  <= dot_q[ACC_W-1];
					dvd_q  <= {mag, {FRAC_BITS{1'b0}}};
					drem_q <= '0;
					quo_q  <= '0;
				end
			end
			ST_DIV: begin
				dvd_q  <= dvd_q << 1;
				drem_q <= div_ge ? drem_sub[ROOT_W-1:0] : drem_sh[ROOT_W-1:0];
				quo_q  <= {quo_q[QUO_W-2:0], div_ge};
			end
			ST_CLAMP: begin
				sim_q <= neg_q ? -signed'(sim_mag) : signed'(sim_mag);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_INSERT) && (pos < k_eff)) begin
			for (int i = 0; i < MAX_TOP_K; i++) begin
				if (KCNT_W'(i) == pos) begin
					best_idx_q[i] <= idx_q;
					best_sim_q[i] <= sim_q;
				end else if ((i > 0) && (KCNT_W'(i) > pos)) begin
					best_idx_q[i] <= best_idx_q[(i > 0) ? i - 1 : 0];
					best_sim_q[i] <= best_sim_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_rank_q <= RANK_W'(ptr_q);
			out_idx_q  <= best_idx_q[ptr_q[KIDX_W-1:0]];
			out_sim_q  <= best_sim_q[ptr_q[KIDX_W-1:0]];
			out_last_q <= (ptr_q + 1'b1) == n_eff;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.rank         = out_rank_q;
	assign results.corpus_index = out_idx_q;
	assign results.similarity   = out_sim_q;
	assign results.last_result  = out_last_q;

`ifndef NO_ASSERTIONS
	a_list_size: assert property (@(posedge clk) disable iff (!arst_n)
		best_cnt_q <= KCNT_W'(MAX_TOP_K))
		else $error("best list holds more entries than its capacity");
	a_emit_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ptr_q <= n_eff))
		else $error("emit pointer ran past the list");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> ((state_q == ST_IDLE) && not_empty))
		else $error("job taken outside the idle state");
`endif

endmodule

### rtl/cosine_similarity_top_k.sv
// ----------------------------------------------------------------------------
// Cosine similarity top-K search
// Streams a query and corpus vectors and reports the K most similar vectors.
// ----------------------------------------------------------------------------
// Vector elements (query and corpus) are taken one per cycle while the job
// queue has space; the front end keeps the query in a 384-entry store and
// accumulates dot product and norms as the elements arrive. At the last
// element of a corpus vector a job goes into a four-entry queue.
// The back end takes one job at a time: it forms the norm product from
// partial products, takes its square root, runs the restoring division,
// clamps the quotient and inserts the result into the sorted list. Corpus
// vectors long enough to cover that work stream without stall; shorter ones
// are limited by the back end. A finish goes through the same queue; the
// back end then emits one result per cycle while the receiver is ready, best
// first. top_k may only be written while idle.
module cosine_similarity_top_k (
	input  logic        clk,
	input  logic        arst_n,
	cstk_in_if.sink     items,
	cstk_out_if.source  results,
	cstk_cfg_if.sink    cfg
);
	import cstk_pkg::*;

	logic              space;
	logic              push;
	job_t              push_job;
	logic              pop;
	job_t              pop_job;
	logic              not_empty;
	logic [TOPK_W-1:0] top_k_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q <= TOP_K_RESET;
		end else if (cfg.valid && cfg.ready) begin
			top_k_q <= cfg.data;
		end
	end

	cstk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.space    (space),
		.push     (push),
		.push_job (push_job)
	);

	cstk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.space     (space),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (not_empty)
	);

	cstk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_job   (pop_job),
		.pop       (pop),
		.top_k     (top_k_q),
		.results   (results)
	);

endmodule
